>>> rtl/ldpf_pkg.sv
// Package for the line-delimited packet FIFO core.
// Holds transaction payload structs, status and command codes, and controller states.
// No dependencies.
package ldpf_pkg;

   localparam int BUFFER_SIZE_DEF = 64;
   localparam int BYTE_W          = 8;
   localparam int RUN_LEN_W       = 7;
   localparam int MAX_LEN_W       = 16;
   localparam int PKT_LEN_W       = 6;
   localparam int STATUS_W        = 3;
   localparam logic [BYTE_W-1:0] DELIMITER_RESET = 8'd10;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_GET  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK              = 3'd0,
      STAT_NO_NEW_DATA     = 3'd1,
      STAT_NO_DELIM        = 3'd2,
      STAT_NO_DELIM_FULL   = 3'd3,
      STAT_PACKET_TOO_LONG = 3'd4,
      STAT_RUN_TOO_LONG    = 3'd5,
      STAT_FULL            = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_CHECK,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic                 cmd;
      logic [BYTE_W-1:0]    data_byte;
      logic                 run_first;
      logic [RUN_LEN_W-1:0] run_length;
      logic [MAX_LEN_W-1:0] max_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [BYTE_W-1:0]    packet_byte;
      logic [PKT_LEN_W-1:0] packet_length;
      logic                 last;
   } rsp_type;

endpackage

>>> rtl/line_delimited_packet_fifo_core.sv
// Top level of the line-delimited packet FIFO: controller, indices, counts, delimiter register.
// Depends on ldpf_pkg and ldpf_ring_ram.
//
//   channel  | ports                                 | handshake
//   ---------+---------------------------------------+--------------------------------
//   request  | start, busy, req_payload              | taken when start && !busy
//   response | rsp_strobe, rsp_payload               | one strobe per result, no stall
//   csr      | csr_wr_en, csr_wr_data                | delimiter written when csr_wr_en
//
// Push transaction: busy stays low; the status of a first byte shows the next cycle.
// Get transaction: busy while the controller searches the store byte by byte and then emits
// the packet bytes, paced by the single read port of the ring store and its registered read
// data; each packet byte passes the read register and then the response register.
// Reset clears head, tail and search indices, fill and search counts and flags, not the store.
// The receiver cannot stall; busy holds requests off while a get walks the store.
module line_delimited_packet_fifo_core
   import ldpf_pkg::*;
#(
   parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_payload,
   output logic              rsp_strobe,
   output rsp_type           rsp_payload,
   input  logic              csr_wr_en,
   input  logic [BYTE_W-1:0] csr_wr_data
);

   localparam int PW = $clog2(BUFFER_SIZE);
   localparam int CW = $clog2(BUFFER_SIZE + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(BUFFER_SIZE - 1);

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [CW-1:0] n);
      logic [PW+CW-1:0] sum;
      sum = (PW+CW)'(p) + (PW+CW)'(n);
      if (sum >= (PW+CW)'(BUFFER_SIZE)) begin
         sum = sum - (PW+CW)'(BUFFER_SIZE);
      end
      ptr_add = sum[PW-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [PW-1:0]        head_ff, head_in;
   logic [PW-1:0]        tail_ff, tail_in;
   logic [PW-1:0]        search_ff, search_in;
   logic [PW-1:0]        emit_ptr_ff, emit_ptr_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        unsearched_ff, unsearched_in;
   logic [CW-1:0]        searched_ff, searched_in;
   logic                 fresh_ff, fresh_in;
   logic                 run_acc_ff, run_acc_in;
   logic [RUN_LEN_W-1:0] run_rem_ff, run_rem_in;
   logic [BYTE_W-1:0]    delim_ff;
   logic [MAX_LEN_W-1:0] maxlen_ff, maxlen_in;
   logic [PKT_LEN_W-1:0] pkt_len_ff, pkt_len_in;
   logic [PKT_LEN_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic                 emit_vld_ff, emit_vld_in;
   logic                 emit_last_ff, emit_last_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 found;
   logic                 too_long;
   logic                 emit_done;
   logic                 wr_en;
   logic [PW-1:0]        rd_addr;
   logic [BYTE_W-1:0]    rd_data;

   ldpf_ring_ram #(
      .DEPTH (BUFFER_SIZE),
      .AW    (PW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (head_ff),
      .wr_data (req_payload.data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != S_IDLE) || emit_vld_ff;
   assign accept    = start && !busy;
   assign found     = (rd_data == delim_ff);
   assign too_long  = (maxlen_ff < MAX_LEN_W'(searched_ff));
   assign emit_done = ((emit_cnt_ff + PKT_LEN_W'(1)) == pkt_len_ff);
   assign rd_addr   = (state_ff == S_EMIT) ? emit_ptr_ff : search_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_payload.cmd == CMD_GET) && fresh_ff) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            state_in = (unsearched_ff == '0) ? S_IDLE : S_CHECK;
         end
         S_CHECK: begin
            if (!found) begin
               state_in = S_SEARCH;
            end else if (too_long) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      logic                 acc;
      logic [RUN_LEN_W-1:0] rem;
      logic [CW-1:0]        fill_left;
      acc           = run_acc_ff;
      rem           = run_rem_ff;
      fill_left     = '0;
      head_in       = head_ff;
      tail_in       = tail_ff;
      search_in     = search_ff;
      emit_ptr_in   = emit_ptr_ff;
      fill_in       = fill_ff;
      unsearched_in = unsearched_ff;
      searched_in   = searched_ff;
      fresh_in      = fresh_ff;
      run_acc_in    = run_acc_ff;
      run_rem_in    = run_rem_ff;
      maxlen_in     = maxlen_ff;
      pkt_len_in    = pkt_len_ff;
      emit_cnt_in   = emit_cnt_ff;
      emit_vld_in   = 1'b0;
      emit_last_in  = 1'b0;
      wr_en         = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = '{status: STAT_OK, packet_byte: '0, packet_length: '0, last: 1'b1};

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_payload.cmd == CMD_GET)) begin
               maxlen_in = req_payload.max_length;
               if (!fresh_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.status = STAT_NO_NEW_DATA;
               end
            end else if (accept) begin
               if (req_payload.run_first) begin
                  rsp_strobe_in = 1'b1;
                  rem           = req_payload.run_length;
                  if ({1'b0, req_payload.run_length} > 8'(BUFFER_SIZE)) begin
                     rsp_in.status = STAT_RUN_TOO_LONG;
                     acc           = 1'b0;
                  end else if ((8'(fill_ff) + 8'(req_payload.run_length)) >= 8'(BUFFER_SIZE)) begin
                     rsp_in.status = STAT_FULL;
                     acc           = 1'b0;
                  end else begin
                     rsp_in.status = STAT_OK;
                     acc           = 1'b1;
                     fresh_in      = 1'b1;
                  end
               end
               run_acc_in = acc;
               run_rem_in = rem;
               if (rem != '0) begin
                  run_rem_in = rem - RUN_LEN_W'(1);
                  if (acc && (fill_ff < CW'(BUFFER_SIZE - 1))) begin
                     wr_en         = 1'b1;
                     head_in       = ptr_inc(head_ff);
                     fill_in       = fill_ff + CW'(1);
                     unsearched_in = unsearched_ff + CW'(1);
                     fresh_in      = 1'b1;
                  end
               end
            end
         end
         S_SEARCH: begin
            if (unsearched_ff == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = (fill_ff >= CW'(BUFFER_SIZE)) ? STAT_NO_DELIM_FULL
                                                              : STAT_NO_DELIM;
            end else begin
               search_in     = ptr_inc(search_ff);
               unsearched_in = unsearched_ff - CW'(1);
               searched_in   = searched_ff + CW'(1);
            end
         end
         S_CHECK: begin
            if (found && too_long) begin
               search_in     = tail_ff;
               searched_in   = '0;
               unsearched_in = fill_ff;
               if (fill_ff == '0) begin
                  fresh_in = 1'b0;
               end
               rsp_strobe_in = 1'b1;
               rsp_in.status = STAT_PACKET_TOO_LONG;
            end else if (found) begin
               fill_left   = (fill_ff >= searched_ff) ? fill_ff - searched_ff : '0;
               tail_in     = ptr_add(tail_ff, searched_ff);
               fill_in     = fill_left;
               searched_in = '0;
               if (fill_left == '0) begin
                  fresh_in = 1'b0;
               end
               emit_ptr_in = tail_ff;
               emit_cnt_in = '0;
               pkt_len_in  = PKT_LEN_W'(searched_ff);
            end
         end
         S_EMIT: begin
            emit_ptr_in  = ptr_inc(emit_ptr_ff);
            emit_cnt_in  = emit_cnt_ff + PKT_LEN_W'(1);
            emit_vld_in  = 1'b1;
            emit_last_in = emit_done;
         end
         default: ;
      endcase

      if (emit_vld_ff) begin
         rsp_strobe_in = 1'b1;
         rsp_in        = '{status: STAT_OK, packet_byte: rd_data,
                           packet_length: pkt_len_ff, last: emit_last_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         search_ff     <= '0;
         fill_ff       <= '0;
         unsearched_ff <= '0;
         searched_ff   <= '0;
         fresh_ff      <= 1'b0;
         run_acc_ff    <= 1'b0;
         run_rem_ff    <= '0;
         emit_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         search_ff     <= search_in;
         fill_ff       <= fill_in;
         unsearched_ff <= unsearched_in;
         searched_ff   <= searched_in;
         fresh_ff      <= fresh_in;
         run_acc_ff    <= run_acc_in;
         run_rem_ff    <= run_rem_in;
         emit_vld_ff   <= emit_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIMITER_RESET;
      end else if (csr_wr_en) begin
         delim_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      emit_ptr_ff  <= emit_ptr_in;
      maxlen_ff    <= maxlen_in;
      pkt_len_ff   <= pkt_len_in;
      emit_cnt_ff  <= emit_cnt_in;
      emit_last_ff <= emit_last_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/ldpf_ring_ram.sv
// Byte ring store: one write port, one read port, registered read data.
// Depends on ldpf_pkg for the byte width.
module ldpf_ring_ram
   import ldpf_pkg::*;
#(
   parameter int DEPTH = BUFFER_SIZE_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
